// ----- src/websocket_frame_deframer_assert.svh -----
// assertion macros used by the port checker
`ifndef WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH

// condition holds at every edge out of reset
`define WSFD_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("%m: check failed");

// antecedent at one edge implies consequent at the next
`define WSFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

// antecedent implies consequent at the same edge
`define WSFD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

`endif

// ----- src/wsfd_pkg.sv -----
// ----------------------------------------------------------------------------
// wsfd_pkg
// Types and constants shared by the frame deframer modules.
// ----------------------------------------------------------------------------
package wsfd_pkg;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_CLOSE = 2'd2;

  localparam logic [3:0] OPC_DATA_MAX = 4'd2;
  localparam logic [3:0] OPC_CLOSE    = 4'd8;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  localparam logic [2:0] EXT16_COUNT = 3'd1;
  localparam logic [2:0] EXT64_COUNT = 3'd7;
  localparam logic [2:0] KEY_COUNT   = 3'd3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // one result on its way from parser to output stage
  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] opcode;
    logic [7:0] data;
    logic [7:0] key;
    logic       last;
  } op_t;

endpackage

// ----- src/wsfd_in_if.sv -----
// ----------------------------------------------------------------------------
// wsfd_in_if
// Byte stream channel into the deframer.
// ----------------------------------------------------------------------------
interface wsfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ----- src/wsfd_out_if.sv -----
// ----------------------------------------------------------------------------
// wsfd_out_if
// Result channel out of the deframer.
// ----------------------------------------------------------------------------
interface wsfd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [3:0] frame_opcode;
  logic [7:0] payload_byte;
  logic       last_in_frame;

  modport source (output valid, output kind, output frame_opcode, output payload_byte,
                  output last_in_frame, input ready);
  modport sink (input valid, input kind, input frame_opcode, input payload_byte,
                input last_in_frame, output ready);
endinterface

// ----- src/wsfd_front.sv -----
// ----------------------------------------------------------------------------
// wsfd_front
// Header parser: tracks frame phase, length and mask key, and queues one
// result request per byte that produces one.
// ----------------------------------------------------------------------------
module wsfd_front
  import wsfd_pkg::*;
#(
  parameter int LENGTH_BITS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  output logic       in_ready,
  input  logic       q_full,
  output logic       push,
  output op_t        push_op
);

  phase_t                 phase_r, phase_nxt;
  logic [3:0]             opcode_r, opcode_nxt;
  logic                   masked_r, masked_nxt;
  logic [2:0]             hcnt_r, hcnt_nxt;
  logic [LENGTH_BITS-1:0] rem_r, rem_nxt;
  logic [3:0][7:0]        key_r, key_nxt;
  logic [1:0]             midx_r, midx_nxt;

  logic accept;
  logic len_done;
  logic hdr_done;
  logic is_data;
  logic last;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_data  = (opcode_r <= OPC_DATA_MAX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR0;
      opcode_r <= '0;
      masked_r <= 1'b0;
      hcnt_r   <= '0;
      rem_r    <= '0;
      key_r    <= '0;
      midx_r   <= '0;
    end else begin
      phase_r  <= phase_nxt;
      opcode_r <= opcode_nxt;
      masked_r <= masked_nxt;
      hcnt_r   <= hcnt_nxt;
      rem_r    <= rem_nxt;
      key_r    <= key_nxt;
      midx_r   <= midx_nxt;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    opcode_nxt = opcode_r;
    masked_nxt = masked_r;
    hcnt_nxt   = hcnt_r;
    rem_nxt    = rem_r;
    key_nxt    = key_r;
    midx_nxt   = midx_r;
    len_done   = 1'b0;
    hdr_done   = 1'b0;
    last       = 1'b0;
    push       = 1'b0;
    push_op    = '0;
    push_op.opcode = opcode_r;

    if (accept) begin
      case (phase_r)
        PH_HDR1: begin
          masked_nxt = in_byte[7];
          key_nxt    = '0;
          rem_nxt    = '0;
          if (in_byte[6:0] == LEN7_EXT16) begin
            phase_nxt = PH_EXTLEN;
            hcnt_nxt  = EXT16_COUNT;
          end else if (in_byte[6:0] == LEN7_EXT64) begin
            phase_nxt = PH_EXTLEN;
            hcnt_nxt  = EXT64_COUNT;
          end else begin
            rem_nxt  = {{(LENGTH_BITS-7){1'b0}}, in_byte[6:0]};
            len_done = 1'b1;
          end
        end
        PH_EXTLEN: begin
          rem_nxt = {rem_r[LENGTH_BITS-9:0], in_byte};
          if (hcnt_r == '0) begin
            len_done = 1'b1;
          end else begin
            hcnt_nxt = hcnt_r - 3'd1;
          end
        end
        PH_MASK: begin
          key_nxt = {key_r[2:0], in_byte};
          if (hcnt_r == '0) begin
            hdr_done = 1'b1;
          end else begin
            hcnt_nxt = hcnt_r - 3'd1;
          end
        end
        PH_PAYLOAD: begin
          midx_nxt = midx_r + 2'd1;
          rem_nxt  = rem_r - LENGTH_BITS'(1);
          last     = (rem_r == LENGTH_BITS'(1));
          if (last) begin
            phase_nxt = PH_HDR0;
          end
          if (is_data) begin
            push         = 1'b1;
            push_op.kind = KIND_BYTE;
            push_op.data = in_byte;
            push_op.key  = masked_r ? key_r[~midx_r] : 8'd0;
            push_op.last = last;
          end else if (opcode_r == OPC_CLOSE && last) begin
            push         = 1'b1;
            push_op.kind = KIND_CLOSE;
            push_op.last = 1'b1;
          end
        end
        default: begin
          opcode_nxt = in_byte[3:0];
          phase_nxt  = PH_HDR1;
        end
      endcase

      if (len_done) begin
        if (masked_nxt) begin
          phase_nxt = PH_MASK;
          hcnt_nxt  = KEY_COUNT;
        end else begin
          hdr_done = 1'b1;
        end
      end

      if (hdr_done) begin
        midx_nxt = '0;
        if (rem_nxt == '0) begin
          phase_nxt = PH_HDR0;
          if (is_data) begin
            push         = 1'b1;
            push_op.kind = KIND_EMPTY;
            push_op.last = 1'b1;
          end else if (opcode_r == OPC_CLOSE) begin
            push         = 1'b1;
            push_op.kind = KIND_CLOSE;
            push_op.last = 1'b1;
          end
        end else begin
          phase_nxt = PH_PAYLOAD;
        end
      end
    end
  end

endmodule

// ----- src/wsfd_queue.sv -----
// ----------------------------------------------------------------------------
// wsfd_queue
// Short queue of result requests between parser and output stage.
// ----------------------------------------------------------------------------
module wsfd_queue
  import wsfd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  input  logic pop,
  output logic pop_valid,
  output op_t  pop_op
);

  op_t                 entry_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]   count_r, count_nxt;
  logic                do_pop;

  assign full      = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_op    = entry_r[rd_ptr_r];
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QUEUE_AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QUEUE_AW'(1);
    end
    case ({push, do_pop})
      2'b10:   count_nxt = count_r + (QUEUE_AW+1)'(1);
      2'b01:   count_nxt = count_r - (QUEUE_AW+1)'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

// ----- src/wsfd_back.sv -----
// ----------------------------------------------------------------------------
// wsfd_back
// Output stage: unmasks payload bytes and holds the result register.
// ----------------------------------------------------------------------------
module wsfd_back
  import wsfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  op_t        q_op,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [3:0] out_frame_opcode,
  output logic [7:0] out_payload_byte,
  output logic       out_last_in_frame
);

  logic       valid_r, valid_nxt;
  logic [1:0] kind_r;
  logic [3:0] opcode_r;
  logic [7:0] byte_r;
  logic       last_r;

  assign q_pop     = q_valid && (!valid_r || out_ready);
  assign valid_nxt = q_pop || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind_r   <= q_op.kind;
      opcode_r <= q_op.opcode;
      byte_r   <= q_op.data ^ q_op.key;
      last_r   <= q_op.last;
    end
  end

  assign out_valid         = valid_r;
  assign out_kind          = kind_r;
  assign out_frame_opcode  = opcode_r;
  assign out_payload_byte  = byte_r;
  assign out_last_in_frame = last_r;

endmodule

// ----- src/websocket_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Parses frames from a received byte stream and emits unmasked payload bytes,
// empty-frame markers and close requests.
// ----------------------------------------------------------------------------
// Takes one stream byte per cycle without gaps as long as results are drained;
// the header parser updates its length counter and key register in the cycle
// a byte is accepted. A result passes through a two-entry queue and the output
// register, and input stalls only when that queue is full. There is no clearing
// pass after reset.
module websocket_frame_deframer
  import wsfd_pkg::*;
#(
  parameter int LENGTH_BITS = 64
) (
  input logic        clk,
  input logic        rst_n,
  wsfd_in_if.sink    in_ch,
  wsfd_out_if.source out_ch
);

  logic q_full;
  logic push;
  op_t  push_op;
  logic q_valid;
  logic q_pop;
  op_t  q_op;

  wsfd_front #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_byte  (in_ch.rx_byte),
    .in_ready (in_ch.ready),
    .q_full   (q_full),
    .push     (push),
    .push_op  (push_op)
  );

  wsfd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_op   (push_op),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_op    (q_op)
  );

  wsfd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_op              (q_op),
    .q_pop             (q_pop),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_kind          (out_ch.kind),
    .out_frame_opcode  (out_ch.frame_opcode),
    .out_payload_byte  (out_ch.payload_byte),
    .out_last_in_frame (out_ch.last_in_frame)
  );

endmodule

// ----- src/wsfd_checker.sv -----
// ----------------------------------------------------------------------------
// wsfd_port_checker
// Port-level checks on the deframer result channel.
// ----------------------------------------------------------------------------
`include "websocket_frame_deframer_assert.svh"

module wsfd_port_checker
  import wsfd_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [7:0] out_payload_byte,
  input logic       out_last_in_frame
);

  // stalled result stays offered
  `WSFD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  `WSFD_ASSERT_IMPL(a_kind_legal, clk, rst_n, out_valid, out_kind != 2'd3)

  // marker results carry no byte and end their frame
  `WSFD_ASSERT_IMPL(a_marker_zero, clk, rst_n, out_valid && out_kind != KIND_BYTE,
                    out_payload_byte == 8'd0 && out_last_in_frame)

  `WSFD_ASSERT_NEXT(a_reset_idle, clk, 1'b1, !rst_n, !out_valid)

endmodule

bind websocket_frame_deframer wsfd_port_checker u_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_kind          (out_ch.kind),
  .out_payload_byte  (out_ch.payload_byte),
  .out_last_in_frame (out_ch.last_in_frame)
);
